// File: rtl/core/rth_pkg.sv
// Shared types, codes and heading arithmetic for the rotate-to-heading controller.
// No dependencies.
package rth_pkg;

  localparam int unsigned HeadingW = 9;
  localparam int unsigned ErrW     = 8;
  localparam int unsigned ThrW     = 8;

  localparam logic [HeadingW-1:0] FullCircle  = 9'd360;
  localparam logic [HeadingW-1:0] HalfCircle  = 9'd180;
  localparam logic [HeadingW-1:0] RecordReset = 9'd360;
  localparam logic [ThrW-1:0]     SlowThrRst  = 8'd25;
  localparam logic [ThrW-1:0]     ArriveThrRst = 8'd5;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_ABORT  = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    MOTOR_STOP  = 2'd0,
    MOTOR_LEFT  = 2'd1,
    MOTOR_RIGHT = 2'd2
  } motor_t;

  typedef enum logic {
    CFG_SLOW_THR   = 1'b0,
    CFG_ARRIVE_THR = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]      motor_cmd;
    logic            half_speed;
    logic            done_res;
    logic            reversed;
    logic [ErrW-1:0] heading_error;
  } res_t;

  // 0..511 -> 0..359 (one subtract is enough below 720)
  function automatic logic [HeadingW-1:0] norm_heading(input logic [HeadingW-1:0] v);
    norm_heading = (v >= FullCircle) ? v - FullCircle : v;
  endfunction

  // wrapped absolute difference of two headings in 0..359
  function automatic logic [ErrW-1:0] abs_error(input logic [HeadingW-1:0] a,
                                                input logic [HeadingW-1:0] b);
    logic [HeadingW-1:0] d;
    d = (a >= b) ? a - b : b - a;
    if (d > HalfCircle) begin
      d = FullCircle - d;
    end
    abs_error = d[ErrW-1:0];
  endfunction

  // (t - h) mod 360, both in 0..359
  function automatic logic [HeadingW-1:0] fwd_diff(input logic [HeadingW-1:0] t,
                                                  input logic [HeadingW-1:0] h);
    logic [HeadingW:0] d;
    d = {1'b0, t} - {1'b0, h};
    if (d[HeadingW]) begin
      d = d + {1'b0, FullCircle};
    end
    fwd_diff = d[HeadingW-1:0];
  endfunction

endpackage

// File: rtl/core/rth_core.sv
// Controller state, threshold registers and per-transaction result logic.
// Depends on rth_pkg.
module rth_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rth_pkg::ThrW-1:0]      cfg_wdata,
  input  logic                          push,
  input  logic [1:0]                    req_type,
  input  logic [rth_pkg::HeadingW-1:0]  target_heading,
  input  logic [rth_pkg::HeadingW-1:0]  heading,
  output rth_pkg::res_t                 res
);

  logic [rth_pkg::ThrW-1:0]     slow_thr_r, arrive_thr_r;
  logic [rth_pkg::HeadingW-1:0] goal_r, goal_nxt;
  logic                         left_r, left_nxt;
  logic [rth_pkg::HeadingW-1:0] best_r, best_nxt;
  logic                         active_r, active_nxt;
  logic                         slow_r, slow_nxt;

  logic [rth_pkg::HeadingW-1:0] h_n, t_n, fwd;
  logic [rth_pkg::ErrW-1:0]     d;
  rth_pkg::req_t                req;

  assign req = rth_pkg::req_t'(req_type);
  assign h_n = rth_pkg::norm_heading(heading);
  assign t_n = rth_pkg::norm_heading(target_heading);
  assign fwd = rth_pkg::fwd_diff(t_n, h_n);
  assign d   = rth_pkg::abs_error(goal_r, h_n);

  always_comb begin
    goal_nxt   = goal_r;
    left_nxt   = left_r;
    best_nxt   = best_r;
    active_nxt = active_r;
    slow_nxt   = slow_r;
    res        = '0;
    case (req)
      rth_pkg::REQ_START: begin
        goal_nxt   = t_n;
        best_nxt   = rth_pkg::RecordReset;
        active_nxt = 1'b1;
        slow_nxt   = 1'b0;
        if (fwd > rth_pkg::HalfCircle) begin
          left_nxt          = 1'b1;
          res.heading_error = 8'(rth_pkg::FullCircle - fwd);
          res.motor_cmd     = rth_pkg::MOTOR_LEFT;
        end else begin
          left_nxt          = 1'b0;
          res.heading_error = fwd[rth_pkg::ErrW-1:0];
          res.motor_cmd     = rth_pkg::MOTOR_RIGHT;
        end
      end
      rth_pkg::REQ_SAMPLE: begin
        res.heading_error = d;
        if (active_r) begin
          if (d <= arrive_thr_r) begin
            active_nxt   = 1'b0;
            slow_nxt     = 1'b0;
            res.done_res = 1'b1;
          end else begin
            slow_nxt = slow_r | (d < slow_thr_r);
            if ({1'b0, d} <= best_r) begin
              best_nxt = {1'b0, d};
            end else begin
              left_nxt     = ~left_r;
              best_nxt     = rth_pkg::RecordReset;
              res.reversed = 1'b1;
            end
            res.half_speed = slow_nxt;
            res.motor_cmd  = left_nxt ? rth_pkg::MOTOR_LEFT : rth_pkg::MOTOR_RIGHT;
          end
        end
      end
      rth_pkg::REQ_ABORT: begin
        active_nxt = 1'b0;
        slow_nxt   = 1'b0;
      end
      default: begin
        if (active_r) begin
          res.motor_cmd  = left_r ? rth_pkg::MOTOR_LEFT : rth_pkg::MOTOR_RIGHT;
          res.half_speed = slow_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_thr_r   <= rth_pkg::SlowThrRst;
      arrive_thr_r <= rth_pkg::ArriveThrRst;
      goal_r       <= '0;
      left_r       <= 1'b0;
      best_r       <= rth_pkg::RecordReset;
      active_r     <= 1'b0;
      slow_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (rth_pkg::cfg_idx_t'(cfg_index))
          rth_pkg::CFG_SLOW_THR:   slow_thr_r   <= cfg_wdata;
          rth_pkg::CFG_ARRIVE_THR: arrive_thr_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (push) begin
        goal_r   <= goal_nxt;
        left_r   <= left_nxt;
        best_r   <= best_nxt;
        active_r <= active_nxt;
        slow_r   <= slow_nxt;
      end
    end
  end

endmodule

// File: rtl/core/rth_outbuf.sv
// Result register with a one-entry skid stage.
// Depends on rth_pkg.
module rth_outbuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rth_pkg::res_t push_res,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output rth_pkg::res_t out_res
);

  logic          out_valid_r, skid_valid_r;
  rth_pkg::res_t out_res_r, skid_res_r;
  logic          load_out;

  // output stage free this cycle
  assign load_out = !out_valid_r || !out_stall;
  assign full     = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r  <= skid_valid_r | push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r <= skid_valid_r ? skid_res_r : push_res;
    end else if (push) begin
      skid_res_r <= push_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: rtl/core/rotate_to_heading_controller.sv
// Top level of the spin-in-place heading controller.
// Depends on rth_pkg, rth_core and rth_outbuf.
//
// One result transaction per input transaction, one input transaction per clock while
// in_stall is low. A transaction's result is computed in the cycle it is accepted by a
// short subtract/wrap/compare path (rth_core) and registered at that edge in the
// result register, or in the skid entry if that is held. The controller state (goal,
// direction, best error record, active, slow mode) updates in the same edge, so the
// next transaction sees it at once. A skid entry behind the result register keeps
// input accepted for one more transaction while out_stall is high; in_stall rises only
// when both entries hold results. Thresholds must be written through cfg_we/cfg_index/
// cfg_wdata (index 0 slow, 1 arrive) only while idle; the block does not enforce it.
module rotate_to_heading_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rth_pkg::ThrW-1:0]      cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [rth_pkg::HeadingW-1:0]  in_target_heading,
  input  logic [rth_pkg::HeadingW-1:0]  in_heading,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_motor_cmd,
  output logic                          out_half_speed,
  output logic                          out_done_res,
  output logic                          out_reversed,
  output logic [rth_pkg::ErrW-1:0]      out_heading_error
);

  logic          push;
  logic          full;
  rth_pkg::res_t core_res;
  rth_pkg::res_t out_res;

  assign in_stall = full;
  assign push     = in_valid && !full;

  rth_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .push           (push),
    .req_type       (in_req_type),
    .target_heading (in_target_heading),
    .heading        (in_heading),
    .res            (core_res)
  );

  rth_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (core_res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_motor_cmd     = out_res.motor_cmd;
  assign out_half_speed    = out_res.half_speed;
  assign out_done_res      = out_res.done_res;
  assign out_reversed      = out_res.reversed;
  assign out_heading_error = out_res.heading_error;

endmodule

// File: sim/tb.sv
// Self-checking testbench for rotate_to_heading_controller: directed and random
// start/sample/abort traffic scored against a cycle-free predictor of the controller.
// Depends on rth_pkg and the controller RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Worst phase runs near 60% idle on one side; the limit is far above the real
  // need.
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxPrinted  = 40;

  // Scoreboard: shadows the controller state and queues one expected result per
  // accepted transaction, in acceptance order.
  class heading_scoreboard;
    int unsigned   goal;
    int unsigned   best;
    bit            left;
    bit            active;
    bit            slow;
    int unsigned   slow_thr;
    int unsigned   arrive_thr;
    rth_pkg::res_t expected_q[$];
    int unsigned   mismatches;
    int unsigned   checked;
    int unsigned   arrivals;
    int unsigned   reversals;

    function new();
      goal       = 0;
      best       = 360;
      left       = 1'b0;
      active     = 1'b0;
      slow       = 1'b0;
      slow_thr   = rth_pkg::SlowThrRst;
      arrive_thr = rth_pkg::ArriveThrRst;
      mismatches = 0;
      checked    = 0;
      arrivals   = 0;
      reversals  = 0;
    endfunction

    function void set_threshold(rth_pkg::cfg_idx_t idx, logic [rth_pkg::ThrW-1:0] v);
      if (idx == rth_pkg::CFG_SLOW_THR) begin
        slow_thr = v;
      end else begin
        arrive_thr = v;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function rth_pkg::motor_t motor_state();
      if (!active) begin
        return rth_pkg::MOTOR_STOP;
      end
      return left ? rth_pkg::MOTOR_LEFT : rth_pkg::MOTOR_RIGHT;
    endfunction

    // Advance the shadow state by one accepted transaction.
    function void note_input(rth_pkg::req_t req, logic [rth_pkg::HeadingW-1:0] tgt,
                             logic [rth_pkg::HeadingW-1:0] hdg);
      int unsigned   h;
      int unsigned   t;
      int unsigned   fwd;
      int unsigned   d;
      rth_pkg::res_t e;
      h = hdg;
      h = h % 360;
      e = '0;
      case (req)
        rth_pkg::REQ_START: begin
          t = tgt;
          t = t % 360;
          fwd = (t + 360 - h) % 360;
          goal = t;
          left = (fwd > 180);
          e.heading_error = 8'(left ? 360 - fwd : fwd);
          best = 360;
          active = 1'b1;
          slow = 1'b0;
          e.motor_cmd = motor_state();
        end
        rth_pkg::REQ_SAMPLE: begin
          d = (goal >= h) ? goal - h : h - goal;
          if (d > 180) begin
            d = 360 - d;
          end
          e.heading_error = 8'(d);
          if (active) begin
            if (d <= arrive_thr) begin
              active = 1'b0;
              slow = 1'b0;
              e.done_res = 1'b1;
              arrivals++;
            end else begin
              if (d < slow_thr) begin
                slow = 1'b1;
              end
              if (d <= best) begin
                best = d;
              end else begin
                left = !left;
                best = 360;
                e.reversed = 1'b1;
                reversals++;
              end
              e.half_speed = slow;
            end
            e.motor_cmd = motor_state();
          end
        end
        rth_pkg::REQ_ABORT: begin
          active = 1'b0;
          slow = 1'b0;
        end
        default: begin
          // no-op: report the current motor state and half-speed flag only
          e.motor_cmd = motor_state();
          e.half_speed = active && slow;
        end
      endcase
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MaxPrinted) begin
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
    endtask

    task check_result(rth_pkg::res_t got);
      rth_pkg::res_t e;
      if (expected_q.size() == 0) begin
        report("result transaction with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.motor_cmd !== e.motor_cmd) begin
        report($sformatf("motor_cmd got %0d want %0d", got.motor_cmd, e.motor_cmd));
      end
      if (got.half_speed !== e.half_speed) begin
        report($sformatf("half_speed got %0b want %0b", got.half_speed, e.half_speed));
      end
      if (got.done_res !== e.done_res) begin
        report($sformatf("done_res got %0b want %0b", got.done_res, e.done_res));
      end
      if (got.reversed !== e.reversed) begin
        report($sformatf("reversed got %0b want %0b", got.reversed, e.reversed));
      end
      if (got.heading_error !== e.heading_error) begin
        report($sformatf("heading_error got %0d want %0d", got.heading_error,
                         e.heading_error));
      end
    endtask
  endclass

  logic                         clk;
  logic                         rst_n             = 1'b0;
  logic                         cfg_we            = 1'b0;
  rth_pkg::cfg_idx_t            cfg_index         = rth_pkg::CFG_SLOW_THR;
  logic [rth_pkg::ThrW-1:0]     cfg_wdata         = '0;
  logic                         in_valid          = 1'b0;
  logic                         in_stall;
  rth_pkg::req_t                in_req_type       = rth_pkg::REQ_NOP;
  logic [rth_pkg::HeadingW-1:0] in_target_heading = '0;
  logic [rth_pkg::HeadingW-1:0] in_heading        = '0;
  logic                         out_valid;
  logic                         out_stall         = 1'b0;
  logic [1:0]                   out_motor_cmd;
  logic                         out_half_speed;
  logic                         out_done_res;
  logic                         out_reversed;
  logic [rth_pkg::ErrW-1:0]     out_heading_error;

  heading_scoreboard sb = new();

  // Idle odds in percent per cycle, changed between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent    = 0;
  int unsigned cycles        = 0;

  rotate_to_heading_controller DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_target_heading (in_target_heading),
    .in_heading        (in_heading),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_motor_cmd     (out_motor_cmd),
    .out_half_speed    (out_half_speed),
    .out_done_res      (out_done_res),
    .out_reversed      (out_reversed),
    .out_heading_error (out_heading_error)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("watchdog expired after %0d cycles, %0d results outstanding",
               cycles, sb.pending());
      $display("rotate_to_heading_controller regression: fail");
      $finish;
    end
  end

  // Receiver back-pressure: a fresh coin per cycle, applied on the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result monitor: sample on the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(rth_pkg::res_t'({out_motor_cmd, out_half_speed, out_done_res,
                                       out_reversed, out_heading_error}));
    end
  end

  function automatic logic [rth_pkg::HeadingW-1:0] any_heading();
    return 9'($urandom_range(511));
  endfunction

  // Present one transaction and hold it until accepted. Valid stays high into the
  // next call unless the sender decides to idle there.
  task automatic send_item(rth_pkg::req_t req, logic [rth_pkg::HeadingW-1:0] tgt,
                           logic [rth_pkg::HeadingW-1:0] hdg);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_req_type       = req;
    in_target_heading = tgt;
    in_heading        = hdg;
    in_valid          = 1'b1;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sb.note_input(req, tgt, hdg);
    items_sent++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_threshold(rth_pkg::cfg_idx_t idx, logic [rth_pkg::ThrW-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    sb.set_threshold(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Thresholds change only with the pipe empty: every result has come back.
  task automatic set_thresholds(logic [rth_pkg::ThrW-1:0] slow_v,
                                logic [rth_pkg::ThrW-1:0] arrive_v);
    go_quiet();
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    write_threshold(rth_pkg::CFG_SLOW_THR, slow_v);
    write_threshold(rth_pkg::CFG_ARRIVE_THR, arrive_v);
  endtask

  // Mostly rotation episodes: a start, then compass samples that follow the
  // commanded direction with random step sizes (so overshoot and reversal
  // happen), the odd glitch, abort, no-op or restart. The rest is raw noise.
  task automatic run_traffic(int unsigned n);
    int unsigned first;
    int unsigned target;
    int unsigned plant;
    int unsigned step;
    int unsigned steps;
    int unsigned roll;
    int unsigned k;
    first = items_sent;
    while (items_sent - first < n) begin
      if ($urandom_range(99) < 15) begin
        send_item(rth_pkg::req_t'($urandom_range(3)), any_heading(), any_heading());
      end else begin
        target = $urandom_range(359);
        plant  = $urandom_range(359);
        // out-of-range goals alias onto 0..151
        if (target < 152 && $urandom_range(9) == 0) begin
          send_item(rth_pkg::REQ_START, 9'(target + 360), 9'(plant));
        end else begin
          send_item(rth_pkg::REQ_START, 9'(target), 9'(plant));
        end
        steps = $urandom_range(20, 3);
        for (k = 0; k < steps && sb.active; k++) begin
          roll = $urandom_range(99);
          if (roll < 4) begin
            send_item(rth_pkg::REQ_ABORT, any_heading(), any_heading());
          end else if (roll < 9) begin
            send_item(rth_pkg::REQ_NOP, any_heading(), any_heading());
          end else if (roll < 12) begin
            send_item(rth_pkg::REQ_START, 9'($urandom_range(359)), 9'(plant));
          end else begin
            step = sb.slow ? $urandom_range(8) : $urandom_range(35);
            plant = sb.left ? (plant + 360 - step) % 360 : (plant + step) % 360;
            if ($urandom_range(9) == 0) begin
              plant = $urandom_range(359);
            end
            if (plant < 152 && $urandom_range(19) == 0) begin
              send_item(rth_pkg::REQ_SAMPLE, any_heading(), 9'(plant + 360));
            end else begin
              send_item(rth_pkg::REQ_SAMPLE, any_heading(), 9'(plant));
            end
          end
        end
      end
    end
  endtask

  initial begin
    // Synchronous reset, released on a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 11;
    recv_idle_pct = 60;

    // Directed checks at the reset thresholds (slow 25, arrive 5).
    send_item(rth_pkg::REQ_SAMPLE, 9'd0, 9'd0);      // idle sample against reset goal
    send_item(rth_pkg::REQ_NOP, 9'd0, 9'd0);         // no-op while idle
    send_item(rth_pkg::REQ_ABORT, 9'd0, 9'd0);       // abort while idle
    send_item(rth_pkg::REQ_SAMPLE, 9'd0, 9'd511);    // 511 aliases to 151
    send_item(rth_pkg::REQ_START, 9'd0, 9'd180);     // exact half turn goes right
    send_item(rth_pkg::REQ_START, 9'd180, 9'd0);     // +180 also right
    send_item(rth_pkg::REQ_START, 9'd359, 9'd0);     // one degree to the left
    send_item(rth_pkg::REQ_START, 9'd511, 9'd360);   // both out of range
    send_item(rth_pkg::REQ_START, 9'd90, 9'd0);      // restart while active
    send_item(rth_pkg::REQ_SAMPLE, 9'd0, 9'd40);     // error 50
    send_item(rth_pkg::REQ_SAMPLE, 9'd0, 9'd65);     // error 25: on slow threshold
    send_item(rth_pkg::REQ_SAMPLE, 9'd0, 9'd66);     // error 24: half speed
    send_item(rth_pkg::REQ_NOP, 9'd0, 9'd0);         // no-op reports half speed
    send_item(rth_pkg::REQ_SAMPLE, 9'd0, 9'd66);     // equal to record: no reversal
    send_item(rth_pkg::REQ_SAMPLE, 9'd0, 9'd60);     // error grew: reverse, stays slow
    send_item(rth_pkg::REQ_SAMPLE, 9'd0, 9'd85);     // error 5: arrive, done
    send_item(rth_pkg::REQ_SAMPLE, 9'd0, 9'd90);     // idle after arrival
    send_item(rth_pkg::REQ_START, 9'd10, 9'd350);    // right across north
    send_item(rth_pkg::REQ_SAMPLE, 9'd0, 9'd455);    // out-of-range sample
    send_item(rth_pkg::REQ_ABORT, 9'd0, 9'd0);       // abort while active
    send_item(rth_pkg::REQ_NOP, 9'd0, 9'd0);
    send_item(rth_pkg::REQ_START, 9'd400, 9'd500);   // 40 vs 140: left by 100
    send_item(rth_pkg::REQ_SAMPLE, 9'd0, 9'd43);     // arrive on first sample

    // Random traffic: sender light / receiver heavy idling.
    set_thresholds(8'd0, 8'd0);
    run_traffic(67);
    set_thresholds(8'd180, 8'd180);
    run_traffic(67);

    // Sender heavy / receiver light.
    send_idle_pct = 60;
    recv_idle_pct = 11;
    set_thresholds(8'd127, 8'd75);
    run_traffic(67);
    set_thresholds(8'd10, 8'd40);
    run_traffic(67);

    // Full rate both ways.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_thresholds(8'd60, 8'd2);
    run_traffic(67);
    set_thresholds(8'd25, 8'd5);
    run_traffic(67);

    // Drain, then keep watching the pipe so that any stray result shows.
    go_quiet();
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    $display("ran %0d transactions over 7 threshold settings and 3 idle mixes",
             items_sent);
    $display("%0d results compared: %0d arrivals, %0d reversals, %0d mismatches",
             sb.checked, sb.arrivals, sb.reversals, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("rotate_to_heading_controller regression: pass");
    end else begin
      $display("rotate_to_heading_controller regression: fail");
    end
    $finish;
  end

endmodule
